// File: rtl/core/wbs_pkg.sv
// Shared types and field layout for the word-break segmentability block.
// No dependencies; used by the top level.
package wbs_pkg;

	typedef enum logic [1:0] {
		OP_TEXT      = 2'd0,
		OP_DICT_SYM  = 2'd1,
		OP_ENTRY_LEN = 2'd2,
		OP_START     = 2'd3
	} op_t;

	localparam int OP_W       = 2;
	localparam int ENTRY_W    = 4;
	localparam int POSITION_W = 4;
	localparam int SYMBOL_W   = 8;
	localparam int LENGTH_W   = 5;
	localparam int COUNT_W    = 16;

	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 24;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// File: rtl/core/wbs_dict_mem.sv
// Dictionary memory: one row per entry, each row holding all symbols of that entry.
// Symbol-lane write enables, one synchronous row read per cycle. Uses no package items.
module wbs_dict_mem #(
	parameter int WORDS = 16,
	parameter int LANES = 16,
	parameter int SB    = 8,
	parameter int AW    = 4,
	parameter int LW    = 4
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [LW-1:0]       wr_lane,
	input  logic [SB-1:0]       wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output logic [LANES*SB-1:0] rd_data
);

	logic [LANES*SB-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		for (int p = 0; p < LANES; p++) begin
			if (wr_en && wr_lane == LW'(p)) begin
				mem[wr_addr][p*SB +: SB] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/word_break_segmentability.sv
// A text symbol is accepted only while the block is idle; its result is ready once the
// sequencer has read every dictionary row, one whole row per cycle, from a memory with
// separate read and write ports, then resolved the match and updated history.
// Dictionary writes, length writes and start items give no result and leave the block idle.
// A finished result sits in an output register, so the next item is taken while it waits.
module word_break_segmentability #(
	parameter int MAX_WORDS    = 16,
	parameter int MAX_WORD_LEN = 16,
	parameter int SYMBOL_BITS  = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// op[1:0], entry[5:2], position[9:6], symbol[17:10], length[22:18], zero pad
	input  logic [wbs_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// prefix_ok[0], prefix_length[16:1], zero pad
	output logic [wbs_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int LW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int SB = SYMBOL_BITS;
	localparam int CW = wbs_pkg::COUNT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;

	wbs_pkg::op_t                      op;
	logic [wbs_pkg::ENTRY_W-1:0]       entry;
	logic [wbs_pkg::POSITION_W-1:0]    position;
	logic [wbs_pkg::SYMBOL_W-1:0]      symbol;
	logic [wbs_pkg::LENGTH_W-1:0]      length;

	assign op       = wbs_pkg::op_t'(s_tdata[1:0]);
	assign entry    = s_tdata[5:2];
	assign position = s_tdata[9:6];
	assign symbol   = s_tdata[17:10];
	assign length   = s_tdata[22:18];

	logic        in_xfer;
	logic [8:0]  entry_ext;
	logic [6:0]  position_ext;
	logic [15:0] symbol_ext;
	logic [SB-1:0] sym_in;
	logic        entry_in_range;
	logic        position_in_range;

	assign s_tready          = (state_q == ST_IDLE);
	assign in_xfer           = s_tvalid && s_tready;
	assign entry_ext         = 9'(entry);
	assign position_ext      = 7'(position);
	assign symbol_ext        = 16'(symbol);
	assign sym_in            = symbol_ext[SB-1:0];
	assign entry_in_range    = entry_ext < 9'(MAX_WORDS);
	assign position_in_range = position_ext < 7'(MAX_WORD_LEN);

	// History and entry lengths.
	logic [wbs_pkg::LENGTH_W-1:0] lengths_q [MAX_WORDS];
	logic [SB-1:0]                recent_q [MAX_WORD_LEN];
	logic [MAX_WORD_LEN:0]        flags_q;
	logic [CW-1:0]                count_q;

	// Walk over the dictionary.
	logic [AW-1:0]                addr_q;
	logic                         issue_done_q;
	logic                         rd_en;
	logic                         valid_s1;
	logic                         last_s1;
	logic [wbs_pkg::LENGTH_W-1:0] len_s1;
	logic [MAX_WORD_LEN*SB-1:0]   row_s1;
	logic                         ok_q;

	logic                         ok_out_q;
	logic [CW-1:0]                len_out_q;

	assign rd_en = (state_q == ST_WALK) && !issue_done_q;

	// The memory is written only in the idle state and read only while walking,
	// so a read and a write never overlap.
	wbs_dict_mem #(
		.WORDS (MAX_WORDS),
		.LANES (MAX_WORD_LEN),
		.SB    (SB),
		.AW    (AW),
		.LW    (LW)
	) u_dict (
		.clk     (clk),
		.wr_en   (in_xfer && op == wbs_pkg::OP_DICT_SYM && entry_in_range && position_in_range),
		.wr_addr (entry_ext[AW-1:0]),
		.wr_lane (position_ext[LW-1:0]),
		.wr_data (sym_in),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (row_s1)
	);

	// Match of one dictionary row against the newest symbols. Lane p of the row lines
	// up with the symbol len-1-p places back.
	logic                    len_ok;
	logic                    flag_sel;
	logic [SB-1:0]           sel_sym [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] lane_ok;
	logic                    hit;

	always_comb begin
		len_ok   = (len_s1 != '0) && (7'(len_s1) <= 7'(MAX_WORD_LEN));
		flag_sel = 1'b0;
		for (int k = 0; k < MAX_WORD_LEN; k++) begin
			if (7'(len_s1) == 7'(k + 1)) begin
				flag_sel = flags_q[k];
			end
		end
		for (int p = 0; p < MAX_WORD_LEN; p++) begin
			sel_sym[p] = '0;
			for (int j = 0; j < MAX_WORD_LEN - p; j++) begin
				if (7'(len_s1) == 7'(p + j + 1)) begin
					sel_sym[p] = recent_q[j];
				end
			end
			lane_ok[p] = (7'(p) >= 7'(len_s1)) || (row_s1[p*SB +: SB] == sel_sym[p]);
		end
		hit = len_ok && flag_sel && (&lane_ok);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			last_s1  <= rd_en && (addr_q == AW'(MAX_WORDS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			len_s1 <= lengths_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			ok_q         <= 1'b0;
			flags_q      <= {{MAX_WORD_LEN{1'b0}}, 1'b1};
			count_q      <= '0;
			m_tvalid     <= 1'b0;
			ok_out_q     <= 1'b0;
			len_out_q    <= '0;
			for (int i = 0; i < MAX_WORDS; i++) begin
				lengths_q[i] <= '0;
			end
			for (int i = 0; i < MAX_WORD_LEN; i++) begin
				recent_q[i] <= '0;
			end
		end else begin
			// In the done state the valid flag is handled by the state itself.
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (op)
							wbs_pkg::OP_TEXT: begin
								for (int i = MAX_WORD_LEN - 1; i > 0; i--) begin
									recent_q[i] <= recent_q[i-1];
								end
								recent_q[0]  <= sym_in;
								addr_q       <= '0;
								issue_done_q <= 1'b0;
								ok_q         <= 1'b0;
								state_q      <= ST_WALK;
							end
							wbs_pkg::OP_ENTRY_LEN: begin
								if (entry_in_range) begin
									lengths_q[entry_ext[AW-1:0]] <= length;
								end
							end
							wbs_pkg::OP_START: begin
								for (int i = 0; i < MAX_WORD_LEN; i++) begin
									recent_q[i] <= '0;
								end
								flags_q <= {{MAX_WORD_LEN{1'b0}}, 1'b1};
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						if (addr_q == AW'(MAX_WORDS - 1)) begin
							issue_done_q <= 1'b1;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (valid_s1) begin
						ok_q <= ok_q || hit;
						if (last_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					// Waits here only while an older result is still held.
					if (!m_tvalid || m_tready) begin
						flags_q   <= {flags_q[MAX_WORD_LEN-1:0], ok_q};
						ok_out_q  <= ok_q;
						if (count_q != wbs_pkg::COUNT_MAX) begin
							count_q   <= count_q + 1'b1;
							len_out_q <= count_q + 1'b1;
						end else begin
							len_out_q <= count_q;
						end
						m_tvalid  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tdata = {7'd0, len_out_q, ok_out_q};

	// A compare result only shows up while the dictionary walk is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_WALK)
		else $error("row compare outside the dictionary walk");

	// The last row of a walk is always a real read.
	assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> valid_s1)
		else $error("last-row mark without a read");

	// A text symbol closes the input until its walk is over.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[1:0] == wbs_pkg::OP_TEXT) |=> !s_tready)
		else $error("input open during a dictionary walk");

	// Every result counts at least the symbol that caused it.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[16:1] != '0)
		else $error("result with zero prefix length");

endmodule
